// ----- rtl/wfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wfe_pkg;

   localparam logic [1:0] KIND_BINARY   = 2'd0;
   localparam logic [1:0] KIND_PING     = 2'd1;
   localparam logic [1:0] KIND_PONG     = 2'd2;
   localparam logic [1:0] KIND_CLOSE    = 2'd3;

   localparam logic [1:0] SUB_SUBSCRIBE = 2'd1;
   localparam logic [1:0] SUB_CANCEL    = 2'd2;

   localparam logic       CMD_HEADER    = 1'b0;
   localparam logic       CMD_PAYLOAD   = 1'b1;

   localparam logic [7:0]  OP_BINARY    = 8'h82;
   localparam logic [7:0]  OP_PING      = 8'h89;
   localparam logic [7:0]  OP_PONG      = 8'h8A;
   localparam logic [7:0]  OP_CLOSE     = 8'h88;

   localparam logic [7:0]  MASK_BIT     = 8'h80;
   localparam logic [7:0]  LEN_CODE_16  = 8'd126;
   localparam logic [7:0]  LEN_CODE_64  = 8'd127;
   localparam logic [32:0] SHORT_MAX    = 33'd125;
   localparam logic [32:0] MID_MAX      = 33'h0_0000_FFFF;

   typedef enum logic [1:0] {
      LEN_SHORT = 2'd0,
      LEN_16    = 2'd1,
      LEN_64    = 2'd2
   } len_form_type;

   typedef struct packed {
      logic        command;
      logic [1:0]  frame_kind;
      logic        more_parts;
      logic        cmd_message;
      logic [1:0]  sub_kind;
      logic [31:0] payload_length;
      logic [31:0] mask_key;
      logic [7:0]  data_byte;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   // One queued job: a full header, or a single payload byte already masked.
   typedef struct packed {
      logic         hdr;
      logic [7:0]   op_byte;     // opcode byte, or the payload byte
      len_form_type len_form;
      logic [32:0]  size;
      logic         masked;
      logic [31:0]  key;
      logic         has_flags;
      logic [7:0]   flags_byte;
      logic         has_mark;
      logic [7:0]   mark_byte;
      logic         fend;
   } desc_type;

endpackage

`default_nettype wire

// ----- rtl/websocket_frame_encoder.sv -----
// WebSocket frame encoder, one wire byte per result item.
// req channel (req_valid / req_stall / req_item): a header item expands into
// 2 to 16 bytes (opcode, length, optional key, flags and marker bytes); a
// payload item gives one byte XORed with the current frame's rotating key.
// rsp channel (rsp_valid / rsp_stall / rsp_item): bytes in order; run_last
// marks the last byte of each item, frame_end the last byte of the frame.
// csr_wr_en / csr_wr_data set mask_enable, sampled at each header item.
// The first byte of an item passes through the job queue and then the
// output register. The output stage sends one byte per cycle while
// rsp_stall is low, so payload items flow at one per cycle and a header
// item holds the output until its last byte is sent. A QUEUE_DEPTH-entry
// job queue sits between the accepting front and the byte sequencer, so
// input keeps flowing while a header drains or the receiver stalls;
// req_stall rises when it is full. rsp_stall holds the registered byte in
// place; the sequencer waits. Reset (synchronous) empties the queue, drops
// rsp_valid, clears the stored key, key phase and mask_enable.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire wfe_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output wfe_pkg::rsp_type      rsp_item
);

   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_valid;
   wfe_pkg::desc_type push_data;
   wfe_pkg::desc_type head;

   wfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_item    (req_item),
      .q_full      (q_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_data   (push_data)
   );

   wfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (head)
   );

   wfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .head      (head),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ----- rtl/wfe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wfe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_wr_data,
   input  wire logic             req_valid,
   input  wire wfe_pkg::req_type req_item,
   input  wire logic             q_full,
   output logic                  req_stall,
   output logic                  push,
   output wfe_pkg::desc_type     push_data
);

   logic        mask_en_ff, mask_en_in;
   logic [31:0] key_store_ff, key_store_in;
   logic [1:0]  key_phase_ff, key_phase_in;

   logic        accept;
   logic        binary;
   logic        marked;
   logic [31:0] new_key;
   logic [32:0] size;
   logic [7:0]  marker;

   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] phase);
      logic [1:0] idx;
      idx = 2'(2'd3 - phase);
      return key[{idx, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] op_of(input logic [1:0] kind);
      logic [7:0] op;
      case (kind)
         wfe_pkg::KIND_BINARY: op = wfe_pkg::OP_BINARY;
         wfe_pkg::KIND_PING:   op = wfe_pkg::OP_PING;
         wfe_pkg::KIND_PONG:   op = wfe_pkg::OP_PONG;
         wfe_pkg::KIND_CLOSE:  op = wfe_pkg::OP_CLOSE;
         default:              op = wfe_pkg::OP_BINARY;
      endcase
      return op;
   endfunction

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign push      = accept;

   always_comb begin
      binary  = (req_item.frame_kind == wfe_pkg::KIND_BINARY);
      marked  = (req_item.sub_kind == wfe_pkg::SUB_SUBSCRIBE) ||
                (req_item.sub_kind == wfe_pkg::SUB_CANCEL);
      new_key = mask_en_ff ? req_item.mask_key : 32'd0;
      size    = {1'b0, req_item.payload_length} + {32'd0, binary} + {32'd0, marked};
      marker  = (req_item.sub_kind == wfe_pkg::SUB_SUBSCRIBE) ? 8'd1 : 8'd0;

      push_data = '0;
      if (req_item.command == wfe_pkg::CMD_HEADER) begin
         push_data.hdr        = 1'b1;
         push_data.op_byte    = op_of(req_item.frame_kind);
         if (size <= wfe_pkg::SHORT_MAX) begin
            push_data.len_form = wfe_pkg::LEN_SHORT;
         end else if (size <= wfe_pkg::MID_MAX) begin
            push_data.len_form = wfe_pkg::LEN_16;
         end else begin
            push_data.len_form = wfe_pkg::LEN_64;
         end
         push_data.size       = size;
         push_data.masked     = mask_en_ff;
         push_data.key        = req_item.mask_key;
         push_data.has_flags  = binary;
         push_data.flags_byte = {6'd0, req_item.cmd_message, req_item.more_parts} ^
                                key_byte(new_key, 2'd0);
         // marker follows the flags byte when there is one
         push_data.has_mark   = marked;
         push_data.mark_byte  = marker ^ key_byte(new_key, {1'b0, binary});
         push_data.fend       = (req_item.payload_length == 32'd0);
      end else begin
         push_data.hdr      = 1'b0;
         push_data.op_byte  = req_item.data_byte ^ key_byte(key_store_ff, key_phase_ff);
         push_data.len_form = wfe_pkg::LEN_SHORT;
         push_data.fend     = req_item.last_byte;
      end
   end

   always_comb begin
      mask_en_in   = csr_wr_en ? csr_wr_data : mask_en_ff;
      key_store_in = key_store_ff;
      key_phase_in = key_phase_ff;
      if (accept) begin
         if (req_item.command == wfe_pkg::CMD_HEADER) begin
            key_store_in = new_key;
            key_phase_in = 2'({1'b0, binary} + {1'b0, marked});
         end else begin
            key_phase_in = 2'(key_phase_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_en_ff   <= 1'b0;
         key_store_ff <= 32'd0;
         key_phase_ff <= 2'd0;
      end else begin
         mask_en_ff   <= mask_en_in;
         key_store_ff <= key_store_in;
         key_phase_ff <= key_phase_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wfe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wfe_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire wfe_pkg::desc_type push_data,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output wfe_pkg::desc_type      head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   wfe_pkg::desc_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wfe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wfe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire wfe_pkg::desc_type head,
   output logic                   pop,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output wfe_pkg::rsp_type       rsp_item
);

   logic [3:0]       cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   wfe_pkg::rsp_type rsp_item_ff, rsp_item_in;

   logic        load;
   logic        last_now;
   logic [4:0]  pos;
   logic [4:0]  ext_n;
   logic [4:0]  key_start;
   logic [4:0]  flag_pos;
   logic [4:0]  mark_pos;
   logic [4:0]  total;
   logic [63:0] ext_word;
   logic [2:0]  ext_j;
   logic [2:0]  ext_idx;
   logic [1:0]  key_k;
   logic [1:0]  key_idx;
   logic [7:0]  len_byte;
   logic [7:0]  cur_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // header layout: opcode, length code, extended length, key, flags, marker
   always_comb begin
      pos = {1'b0, cnt_ff};
      case (head.len_form)
         wfe_pkg::LEN_16: begin
            ext_n    = 5'd2;
            ext_word = {head.size[15:0], 48'd0};
            len_byte = wfe_pkg::LEN_CODE_16;
         end
         wfe_pkg::LEN_64: begin
            ext_n    = 5'd8;
            ext_word = {31'd0, head.size};
            len_byte = wfe_pkg::LEN_CODE_64;
         end
         default: begin
            ext_n    = 5'd0;
            ext_word = 64'd0;
            len_byte = {1'b0, head.size[6:0]};
         end
      endcase
      if (head.masked) begin
         len_byte = len_byte | wfe_pkg::MASK_BIT;
      end
      key_start = 5'd2 + ext_n;
      flag_pos  = key_start + (head.masked ? 5'd4 : 5'd0);
      mark_pos  = flag_pos + {4'd0, head.has_flags};
      total     = mark_pos + {4'd0, head.has_mark};

      ext_j   = 3'(pos - 5'd2);
      ext_idx = 3'(3'd7 - ext_j);
      key_k   = 2'(pos - key_start);
      key_idx = 2'(2'd3 - key_k);

      if (!head.hdr || pos == 5'd0) begin
         cur_byte = head.op_byte;
      end else if (pos == 5'd1) begin
         cur_byte = len_byte;
      end else if (pos < key_start) begin
         cur_byte = ext_word[{ext_idx, 3'b000} +: 8];
      end else if (pos < flag_pos) begin
         cur_byte = head.key[{key_idx, 3'b000} +: 8];
      end else if (pos == flag_pos && head.has_flags) begin
         cur_byte = head.flags_byte;
      end else begin
         cur_byte = head.mark_byte;
      end

      last_now = !head.hdr || (pos == 5'(total - 5'd1));
   end

   assign load = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && last_now;

   always_comb begin
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_item_in.out_byte  = cur_byte;
         rsp_item_in.run_last  = last_now;
         rsp_item_in.frame_end = last_now && head.fend;
         cnt_in = last_now ? 4'd0 : 4'(cnt_ff + 4'd1);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

`default_nettype wire
